/* rtl/plane_residual_rms_stats_unit_defines.svh */
// assertion macros for the plane residual statistics block
// used by the top level only; expects clk and rst in scope
`ifndef PLANE_RESIDUAL_RMS_STATS_UNIT_DEFINES_SVH
`define PLANE_RESIDUAL_RMS_STATS_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define PRS_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("prs assertion failed");

// condition holds in the following cycle
`define PRS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("prs assertion failed");

`endif

/* rtl/prs_pkg.sv */
// shared types and constants for the plane residual statistics block
// no dependencies
package prs_pkg;

  localparam int unsigned MaxPoints = 16777216;
  localparam logic [24:0] CountCap = (MaxPoints < 33554431) ? 25'(MaxPoints) : 25'h1FFFFFF;

  localparam logic [1:0] CFG_NORMAL_X = 2'd0;
  localparam logic [1:0] CFG_NORMAL_Y = 2'd1;
  localparam logic [1:0] CFG_NORMAL_Z = 2'd2;
  localparam logic [1:0] CFG_DISTANCE = 2'd3;

  localparam logic KIND_RESIDUAL = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // one queued job: a residual, plus a statistics snapshot on a segment end
  typedef struct packed {
    logic signed [31:0] residual;
    logic               sat;
    logic               summary;
    logic [63:0]        sum;
    logic [24:0]        count;
    logic signed [31:0] min_r;
    logic signed [31:0] max_r;
    logic               ovf;
  } prs_job_t;

  // request to the shared serial divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } prs_div_req_t;

endpackage

/* rtl/prs_intf.sv */
// stream interfaces for points in and results out
// depends on nothing
interface prs_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface prs_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] residual;
  logic               residual_saturated;
  logic [24:0]        point_count;
  logic [63:0]        mean_squared;
  logic [31:0]        root_mean_squared;
  logic [31:0]        normalized_rms;
  logic               range_zero;
  logic               stats_overflow;
  logic               last;
  modport source (output valid, result_kind, residual, residual_saturated, point_count,
                  mean_squared, root_mean_squared, normalized_rms, range_zero,
                  stats_overflow, last, input ready);
  modport sink (input valid, result_kind, residual, residual_saturated, point_count,
                mean_squared, root_mean_squared, normalized_rms, range_zero,
                stats_overflow, last, output ready);
endinterface

/* rtl/prs_queue.sv */
// two-entry job queue between front and back end
// depends on prs_pkg
module prs_queue import prs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  prs_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output prs_job_t head
);
  prs_job_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end
endmodule

/* rtl/prs_div.sv */
// serial restoring divider, one quotient bit per cycle, 64 by 32 bits
// depends on prs_pkg
module prs_div import prs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  prs_div_req_t req,
  output logic         done,
  output logic [63:0]  quotient
);
  logic        busy;
  logic [5:0]  step;
  logic [32:0] rem;
  logic [31:0] divisor;
  logic [32:0] rem_shift;
  logic        ge;

  assign rem_shift = {rem[31:0], quotient[63]};
  assign ge        = (rem_shift >= {1'b0, divisor});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 6'd0;
      end else if (busy) begin
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= 33'd0;
      quotient <= req.dividend;
      divisor  <= req.divisor;
    end else if (busy) begin
      rem      <= ge ? (rem_shift - {1'b0, divisor}) : rem_shift;
      quotient <= {quotient[62:0], ge};
    end
  end
endmodule

/* rtl/prs_front.sv */
// front end: plane registers, residual pipeline and running statistics
// depends on prs_pkg and prs_point_if
module prs_front import prs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  prs_point_if.sink   pts,
  input  logic        q_full,
  output logic        q_push,
  output prs_job_t    q_job
);
  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_RES  = 3'd2;
  localparam logic [2:0] F_SQ   = 3'd3;
  localparam logic [2:0] F_ACC  = 3'd4;

  logic [2:0]         state;
  logic signed [31:0] normal_x, normal_y, normal_z, plane_distance;
  logic signed [31:0] px, py, pz;
  logic               last_pt;
  logic signed [63:0] prod_x, prod_y, prod_z;
  logic signed [31:0] r;
  logic               sat;
  logic [63:0]        sq;
  logic [63:0]        sum_sq;
  logic [24:0]        count;
  logic signed [31:0] min_r, max_r;
  logic               ovf;

  logic signed [65:0] dot_full;
  logic signed [35:0] dot;
  logic signed [36:0] r_wide;
  logic [64:0]        sum_add;
  logic [63:0]        sum_next;
  logic [24:0]        count_next;
  logic signed [31:0] min_next, max_next;
  logic               ovf_next;

  assign pts.ready = (state == F_IDLE);

  // residual: floor of the dot product, then clip
  assign dot_full = 66'(prod_x) + 66'(prod_y) + 66'(prod_z);
  assign dot      = 36'(dot_full >>> 30);
  assign r_wide   = 37'(plane_distance) - 37'(dot);

  // statistics update
  assign sum_add    = {1'b0, sum_sq} + {1'b0, sq};
  assign sum_next   = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
  assign count_next = (count >= CountCap) ? count : count + 25'd1;
  assign ovf_next   = ovf | sum_add[64] | (count >= CountCap);
  assign min_next   = (r < min_r) ? r : min_r;
  assign max_next   = (r > max_r) ? r : max_r;

  assign q_push          = (state == F_ACC) && !q_full;
  assign q_job.residual  = r;
  assign q_job.sat       = sat;
  assign q_job.summary   = last_pt;
  assign q_job.sum       = sum_next;
  assign q_job.count     = count_next;
  assign q_job.min_r     = min_next;
  assign q_job.max_r     = max_next;
  assign q_job.ovf       = ovf_next;

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x       <= 32'sd0;
      normal_y       <= 32'sd0;
      normal_z       <= 32'sd1073741824;
      plane_distance <= 32'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMAL_X: normal_x <= cfg_data;
        CFG_NORMAL_Y: normal_y <= cfg_data;
        CFG_NORMAL_Z: normal_z <= cfg_data;
        CFG_DISTANCE: plane_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      sum_sq <= 64'd0;
      count  <= 25'd0;
      min_r  <= 32'sh7FFF_FFFF;
      max_r  <= 32'sh8000_0000;
      ovf    <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: if (pts.valid) state <= F_MUL;
        F_MUL: state <= F_RES;
        F_RES: state <= F_SQ;
        F_SQ: state <= F_ACC;
        F_ACC: begin
          if (!q_full) begin
            state <= F_IDLE;
            if (last_pt) begin
              sum_sq <= 64'd0;
              count  <= 25'd0;
              min_r  <= 32'sh7FFF_FFFF;
              max_r  <= 32'sh8000_0000;
              ovf    <= 1'b0;
            end else begin
              sum_sq <= sum_next;
              count  <= count_next;
              min_r  <= min_next;
              max_r  <= max_next;
              ovf    <= ovf_next;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (pts.valid && pts.ready) begin
      px      <= pts.point_x;
      py      <= pts.point_y;
      pz      <= pts.point_z;
      last_pt <= pts.last_point;
    end
    if (state == F_MUL) begin
      prod_x <= normal_x * px;
      prod_y <= normal_y * py;
      prod_z <= normal_z * pz;
    end
    if (state == F_RES) begin
      if (r_wide > 37'sh0_7FFF_FFFF) begin
        r   <= 32'sh7FFF_FFFF;
        sat <= 1'b1;
      end else if (r_wide < -37'sh0_8000_0000) begin
        r   <= 32'sh8000_0000;
        sat <= 1'b1;
      end else begin
        r   <= r_wide[31:0];
        sat <= 1'b0;
      end
    end
    if (state == F_SQ) sq <= 64'(r * r);
  end
endmodule

/* rtl/prs_back.sv */
// back end: emits residuals, computes mean, root and normalised root
// depends on prs_pkg, prs_result_if and prs_div
module prs_back import prs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  prs_job_t     q_head,
  output logic         q_pop,
  prs_result_if.source res
);
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MSE  = 3'd1;
  localparam logic [2:0] B_SQRT = 3'd2;
  localparam logic [2:0] B_NRM  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]         state;
  logic [24:0]        count;
  logic [31:0]        span;
  logic               ovf;
  logic [63:0]        mse;
  logic [63:0]        sq_val;
  logic [33:0]        sq_rem;
  logic [31:0]        sq_root;
  logic [4:0]         sq_step;
  logic [31:0]        nrms;
  prs_div_req_t       div_req;
  logic               div_done;
  logic [63:0]        div_q;
  logic               out_free;
  logic               load_res;
  logic               load_sum;
  logic [33:0]        rem_shift;
  logic [33:0]        trial;
  logic signed [32:0] span_wide;

  prs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free  = !res.valid || res.ready;
  assign load_res  = (state == B_IDLE) && q_valid && out_free;
  assign load_sum  = (state == B_OUT) && out_free;
  assign q_pop     = load_res;
  assign span_wide = 33'(q_head.max_r) - 33'(q_head.min_r);

  // square root digit step
  assign rem_shift = {sq_rem[31:0], sq_val[63:62]};
  assign trial     = {sq_root, 2'b01};

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {39'd0, q_head.count};
    div_req.divisor  = 32'(q_head.count);
    if (load_res && q_head.summary) begin
      div_req.start    = 1'b1;
      div_req.dividend = q_head.sum;
    end else if ((state == B_SQRT) && (sq_step == 5'd31) && (span != 32'd0)) begin
      div_req.start    = 1'b1;
      div_req.dividend = {16'd0, sq_root[30:0], (rem_shift >= trial), 16'd0};
      div_req.divisor  = span;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (load_res || load_sum) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        B_IDLE: if (load_res && q_head.summary) state <= B_MSE;
        B_MSE: if (div_done) state <= B_SQRT;
        B_SQRT: if (sq_step == 5'd31) state <= (span == 32'd0) ? B_OUT : B_NRM;
        B_NRM: if (div_done) state <= B_OUT;
        B_OUT: if (out_free) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // summary datapath
  always_ff @(posedge clk) begin
    if (load_res && q_head.summary) begin
      count <= q_head.count;
      span  <= span_wide[31:0];
      ovf   <= q_head.ovf;
    end
    if ((state == B_MSE) && div_done) begin
      mse     <= div_q;
      sq_val  <= div_q;
      sq_rem  <= 34'd0;
      sq_root <= 32'd0;
      sq_step <= 5'd0;
      nrms    <= 32'd0;
    end
    if (state == B_SQRT) begin
      sq_step <= sq_step + 5'd1;
      sq_val  <= {sq_val[61:0], 2'b00};
      if (rem_shift >= trial) begin
        sq_rem  <= rem_shift - trial;
        sq_root <= {sq_root[30:0], 1'b1};
      end else begin
        sq_rem  <= rem_shift;
        sq_root <= {sq_root[30:0], 1'b0};
      end
    end
    if ((state == B_NRM) && div_done) begin
      if (div_q[63:32] != 32'd0) begin
        nrms <= 32'hFFFF_FFFF;
        ovf  <= 1'b1;
      end else begin
        nrms <= div_q[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_res) begin
      res.result_kind        <= KIND_RESIDUAL;
      res.residual           <= q_head.residual;
      res.residual_saturated <= q_head.sat;
      res.point_count        <= 25'd0;
      res.mean_squared       <= 64'd0;
      res.root_mean_squared  <= 32'd0;
      res.normalized_rms     <= 32'd0;
      res.range_zero         <= 1'b0;
      res.stats_overflow     <= 1'b0;
      res.last               <= !q_head.summary;
    end else if (load_sum) begin
      res.result_kind        <= KIND_SUMMARY;
      res.residual           <= 32'sd0;
      res.residual_saturated <= 1'b0;
      res.point_count        <= count;
      res.mean_squared       <= mse;
      res.root_mean_squared  <= sq_root;
      res.normalized_rms     <= nrms;
      res.range_zero         <= (span == 32'd0);
      res.stats_overflow     <= ovf;
      res.last               <= 1'b1;
    end
  end
endmodule

/* rtl/plane_residual_rms_stats_unit.sv */
// plane residual statistics block, top level
// Points arrive on pts (valid/ready). Each point gives one residual result on
// res; a point with last_point set gives its residual result followed by a
// segment summary (count, mean square, root, normalised root, flags).
// The plane is set through the write port (cfg_we, cfg_index, cfg_data). The user
// must write it only while the block is idle; the block does not enforce this.
// The front end captures a point, then multiplies, forms the residual, squares
// and accumulates; it takes a new point only once the last has accumulated.
// A residual result goes through the queue and the output register, waiting while
// the back end is busy or the output is held. A summary needs a serial divide for
// the mean, a digit-by-digit root and, unless the range is zero, a serial divide
// for the normalised root; the front end keeps taking points meanwhile until the
// two-entry queue is full. Reset restores the default plane (normal along z, zero
// distance) and clears the statistics. When the receiver stalls, the output
// register holds its result, the queue fills and then pts.ready stays low.
// depends on prs_pkg, the stream interfaces, prs_front, prs_queue, prs_back and the defines header
`include "plane_residual_rms_stats_unit_defines.svh"
module plane_residual_rms_stats_unit import prs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  prs_point_if.sink    pts,
  prs_result_if.source res
);
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  prs_job_t q_job;
  prs_job_t q_head;

  prs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pts       (pts),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  prs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  prs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

  // checks
  `PRS_ASSERT_NOW(a_summary_last, res.valid && res.result_kind, res.last)
  `PRS_ASSERT_NOW(a_zero_span_nrms, res.valid && res.range_zero, res.normalized_rms == 32'd0)
  `PRS_ASSERT_NEXT(a_one_at_a_time, pts.valid && pts.ready, !pts.ready)
endmodule

/* test/tb_plane_residual_rms_stats_unit.sv */
// testbench for plane_residual_rms_stats_unit: points in, residuals and segment summaries out
// predicts every result in a scoreboard class and checks them in order
// depends on prs_pkg, prs_intf.sv and the block's rtl
module tb_plane_residual_rms_stats_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import prs_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 200;

  typedef struct {
    int x;
    int y;
    int z;
    bit seg_end;
  } point_t;

  typedef struct {
    logic        kind;
    logic [31:0] residual;
    logic        sat;
    logic [24:0] count;
    logic [63:0] mse;
    logic [31:0] rms;
    logic [31:0] nrms;
    logic        zero;
    logic        ovf;
    logic        last;
  } result_t;

  // plane state, running statistics and the queue of predicted results
  class residual_scoreboard;
    int      nx = 0, ny = 0, nz = 32'sh40000000, plane_dist = 0;
    logic [63:0] sum_sq;
    logic [24:0] seen;
    longint  r_min, r_max;
    bit      ovf_seen;
    result_t awaited[$];
    int      errors = 0;

    function new();
      clear_stats();
    endfunction

    function void clear_stats();
      sum_sq = '0;
      seen = '0;
      r_min = 64'sd2147483647;
      r_max = -64'sd2147483648;
      ovf_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int val);
      case (idx)
        CFG_NORMAL_X: nx = val;
        CFG_NORMAL_Y: ny = val;
        CFG_NORMAL_Z: nz = val;
        default: plane_dist = val;
      endcase
    endfunction

    function logic [31:0] floor_root(logic [63:0] v);
      logic [31:0] root, cand;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        cand = root | (32'd1 << i);
        if (64'(cand) * 64'(cand) <= v) root = cand;
      end
      return root;
    endfunction

    // accepted point: residual result, and a summary on a segment end
    function void note_point(point_t p);
      logic signed [67:0] acc, r68;
      longint  r, span;
      logic [63:0] sq, quo;
      logic [64:0] tot;
      result_t e, s;
      acc = 68'(longint'(nx) * longint'(p.x)) + 68'(longint'(ny) * longint'(p.y))
          + 68'(longint'(nz) * longint'(p.z));
      r68 = 68'(longint'(plane_dist)) - (acc >>> 30);
      e = '{default: '0};
      if (r68 > 68'sd2147483647) begin
        r = 64'sd2147483647;
        e.sat = 1;
      end else if (r68 < -68'sd2147483648) begin
        r = -64'sd2147483648;
        e.sat = 1;
      end else begin
        r = longint'(r68);
      end
      sq = 64'(r * r);
      tot = {1'b0, sum_sq} + {1'b0, sq};
      if (tot[64]) begin
        sum_sq = '1;
        ovf_seen = 1;
      end else begin
        sum_sq = tot[63:0];
      end
      if (seen >= CountCap) ovf_seen = 1;
      else seen = seen + 1;
      if (r < r_min) r_min = r;
      if (r > r_max) r_max = r;
      e.kind = KIND_RESIDUAL;
      e.residual = r[31:0];
      e.last = !p.seg_end;
      awaited = {awaited, e};
      if (!p.seg_end) return;
      s = '{default: '0};
      s.kind = KIND_SUMMARY;
      s.count = seen;
      s.mse = sum_sq / 64'(seen == 0 ? 25'd1 : seen);
      s.rms = floor_root(s.mse);
      span = r_max - r_min;
      s.zero = (span == 0);
      s.ovf = ovf_seen;
      if (!s.zero) begin
        quo = (64'(s.rms) << 16) / 64'(span);
        if (quo > 64'hFFFF_FFFF) begin
          quo = 64'hFFFF_FFFF;
          s.ovf = 1;
        end
        s.nrms = quo[31:0];
      end
      s.last = 1;
      awaited = {awaited, s};
      clear_stats();
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (awaited.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (a.kind !== e.kind) begin
        $error("result_kind: expected %0d, got %0d", e.kind, a.kind); errors++;
      end
      if (a.residual !== e.residual) begin
        $error("residual: expected %0d, got %0d", $signed(e.residual), $signed(a.residual));
        errors++;
      end
      if (a.sat !== e.sat) begin
        $error("residual_saturated: expected %0d, got %0d", e.sat, a.sat); errors++;
      end
      if (a.count !== e.count) begin
        $error("point_count: expected %0d, got %0d", e.count, a.count); errors++;
      end
      if (a.mse !== e.mse) begin
        $error("mean_squared: expected %0h, got %0h", e.mse, a.mse); errors++;
      end
      if (a.rms !== e.rms) begin
        $error("root_mean_squared: expected %0h, got %0h", e.rms, a.rms); errors++;
      end
      if (a.nrms !== e.nrms) begin
        $error("normalized_rms: expected %0h, got %0h", e.nrms, a.nrms); errors++;
      end
      if (a.zero !== e.zero) begin
        $error("range_zero: expected %0d, got %0d", e.zero, a.zero); errors++;
      end
      if (a.ovf !== e.ovf) begin
        $error("stats_overflow: expected %0d, got %0d", e.ovf, a.ovf); errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  bit idling_on = 1;
  int hold_requests = 0;
  int quiet_cycles = 0;
  residual_scoreboard stats_sb = new();

  prs_point_if pts ();
  prs_result_if res ();

  plane_residual_rms_stats_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pts(pts.sink), .res(res.source)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int holds_done, hold_left;
    holds_done = 0;
    hold_left = 0;
    res.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready = 0;
      end else begin
        res.ready = !(idling_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  // result transaction check
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      stats_sb.check_result('{res.result_kind, res.residual, res.residual_saturated,
                              res.point_count, res.mean_squared, res.root_mean_squared,
                              res.normalized_rms, res.range_zero, res.stats_overflow,
                              res.last});
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((pts.valid && pts.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    stats_sb.set_reg(idx, val);
  endtask

  task automatic set_plane(int x, int y, int z, int d);
    write_reg(CFG_NORMAL_X, x);
    write_reg(CFG_NORMAL_Y, y);
    write_reg(CFG_NORMAL_Z, z);
    write_reg(CFG_DISTANCE, d);
  endtask

  // offer one point, with random gaps, until the block takes it
  task automatic send_point(int x, int y, int z, bit seg_end);
    while (idling_on && $urandom_range(0, 99) < 22) begin
      pts.valid = 0;
      @(negedge clk);
    end
    pts.valid = 1;
    pts.point_x = x;
    pts.point_y = y;
    pts.point_z = z;
    pts.last_point = seg_end;
    do @(posedge clk); while (!pts.ready);
    stats_sb.note_point('{x, y, z, seg_end});
    @(negedge clk);
  endtask

  // wait for every expected result, then let the back end settle
  task automatic drain();
    pts.valid = 0;
    while (stats_sb.awaited.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic int rand_normal();
    return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 1)) return int'($urandom);
    return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  // random segments, mostly short so summaries come often
  task automatic random_segments(int n_points);
    int left, len;
    left = n_points;
    while (left > 0) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    pts.valid = 0;
    pts.point_x = 0;
    pts.point_y = 0;
    pts.point_z = 0;
    pts.last_point = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: default plane, single point gives a zero span
    send_point(0, 0, 32'sh0001_0000, 1);
    send_point(32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_point(0, 0, -32'sh8000_0000, 1);
    drain();
    // extreme normals: residuals clip, the sum saturates
    set_plane(32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 32'sh7fff_ffff);
    for (int i = 0; i < 5; i++)
      send_point(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, i == 4);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    send_point(-32'sh8000_0000, 0, 32'sh7fff_ffff, 1);
    drain();
    // dot product with negative products, then a large tight segment
    set_plane(-32'sh4000_0000, -32'sh4000_0000, -32'sh4000_0000, -32'sh8000_0000);
    send_point(1, 3, -7, 0);
    send_point(-1, 0, 5, 1);
    drain();
    set_plane(0, 0, 32'sh4000_0000, 32'sh1000_0000);
    send_point(0, 0, 0, 0);
    send_point(0, 0, 1, 1);
    drain();

    // random phases over several plane settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_plane(0, 0, 32'sh4000_0000, 0);
        1: set_plane(32'sh4000_0000, 0, 0, -32'sh8000_0000);
        2: set_plane(-32'sh4000_0000, -32'sh4000_0000, -32'sh4000_0000, 32'sh7fff_ffff);
        default: set_plane(rand_normal(), rand_normal(), rand_normal(), int'($urandom));
      endcase
      idling_on = (ph != 3);
      if (ph == 4) hold_requests++;
      random_segments(200);
      drain();
    end
    idling_on = 1;

    if (stats_sb.errors == 0 && stats_sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* plane_residual_rms_stats_unit.f */
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_intf.sv
rtl/prs_queue.sv
rtl/prs_div.sv
rtl/prs_front.sv
rtl/prs_back.sv
rtl/plane_residual_rms_stats_unit.sv
test/tb_plane_residual_rms_stats_unit.sv
